>>> src/ltl_pkg.sv
// Package: result types, token codes and character classes for the Lisp token lexer.
`default_nettype none
package ltl_pkg;

  localparam int QDEPTH = 2;

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] T_SYMBOL = 3'd0;
  localparam logic [2:0] T_STRING = 3'd1;
  localparam logic [2:0] T_INT    = 3'd2;
  localparam logic [2:0] T_FLOAT  = 3'd3;
  localparam logic [2:0] T_OPEN   = 3'd4;
  localparam logic [2:0] T_CLOSE  = 3'd5;
  localparam logic [2:0] T_QUOTE  = 3'd6;
  localparam logic [2:0] T_END    = 3'd7;

  localparam logic [1:0] ERR_DIGIT = 2'd0;
  localparam logic [1:0] ERR_QUOTE = 2'd1;
  localparam logic [1:0] ERR_CTRL  = 2'd2;
  localparam logic [1:0] ERR_IDENT = 2'd3;

  localparam logic [7:0] CTRL_LO   = 8'h40;
  localparam logic [7:0] CTRL_HI   = 8'h5f;
  localparam logic [7:0] CTRL_MASK = 8'h1f;
  localparam logic [7:0] ESC_CODE  = 8'h1b;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [5:0] NO_DIGIT  = 6'd36;
  localparam logic [5:0] FRAC_MAX  = 6'd63;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text;
    logic [2:0] ttype;
  } slot_t;

  typedef struct packed {
    logic [1:0]        cnt;
    slot_t [2:0]       slot;
    logic [63:0]       val;
    logic [5:0]        frac;
    logic [1:0]        code;
    logic [31:0]       line;
    logic [15:0]       col;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return b >= "a" && b <= "z";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return is_lower(b) || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_sign(input logic [7:0] b);
    return b == "+" || b == "-";
  endfunction

  function automatic logic is_sym_alpha(input logic [7:0] b);
    logic r;
    case (b)
      "!", "#", "$", "%", "&", "*", ".", "/", ":", "<", "=", ">", "?", "[",
      "]", "^", "_", "{", "|", "}", "~": r = 1'b1;
      default: r = is_alpha(b);
    endcase
    return r;
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return is_sym_alpha(b) || is_digit(b) || is_sign(b);
  endfunction

  function automatic logic [5:0] digit_of(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (is_digit(b)) t = b - "0";
    else if (is_lower(b)) t = b - "a" + 8'd10;
    else if (b >= "A" && b <= "Z") t = b - "A" + 8'd10;
    else t = {2'b00, NO_DIGIT};
    return t[5:0];
  endfunction

endpackage
`default_nettype wire

>>> src/ltl_in_if.sv
// Interfaces: source byte channel and result channel.
`default_nettype none
interface ltl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       at_end;
  modport source (output valid, output in_byte, output at_end, input ready);
  modport sink (input valid, input in_byte, input at_end, output ready);
endinterface

interface ltl_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  res_kind;
  logic        [7:0]  text_byte;
  logic        [2:0]  tok_class;
  logic signed [63:0] int_value;
  logic        [5:0]  frac_digits;
  logic        [1:0]  error_code;
  logic        [31:0] err_line;
  logic        [15:0] err_column;
  logic               last;
  modport source (output valid, output res_kind, output text_byte, output tok_class,
                  output int_value, output frac_digits, output error_code,
                  output err_line, output err_column, output last, input ready);
  modport sink (input valid, input res_kind, input text_byte, input tok_class,
                input int_value, input frac_digits, input error_code,
                input err_line, input err_column, input last, output ready);
endinterface
`default_nettype wire

>>> src/ltl_front.sv
// Front end: lexer state machine, position tracking and value multiply-accumulate.
`default_nettype none
module ltl_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  ltl_in_if.sink               in_chan,
  input  wire logic            q_full,
  output ltl_pkg::push_t       push
);
  import ltl_pkg::*;

  typedef enum logic [3:0] {
    M_BETWEEN, M_SIGN, M_SYMBOL, M_NUMINT, M_RADIX, M_FRAC, M_STRING,
    M_ESC, M_CTRL, M_HEX1, M_HEX2, M_COMMENT
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [63:0] radix_r, radix_nxt;
  logic [5:0]  frac_r, frac_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  sign_r, sign_nxt;
  logic [3:0]  esc_r, esc_nxt;
  logic [31:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic        halt_r, halt_nxt;
  logic        busy_r;
  logic [5:0]  mac_d_r;
  logic [63:0] pll_r;
  logic [31:0] mid_r;

  logic        accept;
  logic [7:0]  b;
  logic        e;
  logic [1:0]  n;
  slot_t [2:0] sl;
  logic        adv, reproc, mac_go;
  logic [5:0]  mac_d, d;
  logic [63:0] val_out;
  logic [5:0]  frac_out;
  logic [1:0]  code;
  logic [7:0]  u;
  logic [63:0] mul_lo;
  logic [31:0] mul_hl, mul_lh;

  assign b = in_chan.in_byte;
  assign e = in_chan.at_end;
  assign in_chan.ready = !busy_r && !q_full;
  assign accept = in_chan.valid && in_chan.ready;

  assign mul_lo = 64'(accum_r[31:0] * radix_r[31:0]);
  assign mul_hl = 32'(accum_r[63:32] * radix_r[31:0]);
  assign mul_lh = 32'(accum_r[31:0] * radix_r[63:32]);

  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    radix_nxt = radix_r;
    frac_nxt  = frac_r;
    neg_nxt   = neg_r;
    sign_nxt  = sign_r;
    esc_nxt   = esc_r;
    halt_nxt  = halt_r;
    n         = 2'd0;
    sl        = '0;
    adv       = 1'b0;
    reproc    = 1'b0;
    mac_go    = 1'b0;
    mac_d     = 6'd0;
    val_out   = 64'd0;
    frac_out  = 6'd0;
    code      = ERR_DIGIT;
    d         = digit_of(b);
    u         = is_lower(b) ? b - CASE_BIT : b;

    case (mode_r)
      M_BETWEEN: begin
      end
      M_SIGN: begin
        if (!e && is_digit(b)) begin
          adv = 1'b1;
          accum_nxt = 64'(d);
          radix_nxt = 64'd10;
          frac_nxt = 6'd0;
          neg_nxt = (sign_r == "-");
          mode_nxt = M_NUMINT;
        end else begin
          sl[n] = '{KIND_TEXT, sign_r, T_SYMBOL};
          n = n + 2'd1;
          if (!e && is_trail(b)) begin
            adv = 1'b1;
            sl[n] = '{KIND_TEXT, b, T_SYMBOL};
            n = n + 2'd1;
            mode_nxt = M_SYMBOL;
          end else begin
            sl[n] = '{KIND_DONE, 8'd0, T_SYMBOL};
            n = n + 2'd1;
            mode_nxt = M_BETWEEN;
            reproc = 1'b1;
          end
        end
      end
      M_SYMBOL: begin
        if (!e && is_trail(b)) begin
          adv = 1'b1;
          sl[n] = '{KIND_TEXT, b, T_SYMBOL};
          n = n + 2'd1;
        end else begin
          sl[n] = '{KIND_DONE, 8'd0, T_SYMBOL};
          n = n + 2'd1;
          mode_nxt = M_BETWEEN;
          reproc = 1'b1;
        end
      end
      M_NUMINT, M_RADIX, M_FRAC: begin
        if (mode_r == M_NUMINT && !e && is_digit(b)) begin
          adv = 1'b1;
          mac_go = 1'b1;
          mac_d = d;
        end else if (mode_r == M_NUMINT && !e && b == "x") begin
          adv = 1'b1;
          radix_nxt = (accum_r != 64'd0) ? accum_r : 64'd16;
          accum_nxt = 64'd0;
          mode_nxt = M_RADIX;
        end else if (mode_r == M_NUMINT && !e && b == ".") begin
          adv = 1'b1;
          frac_nxt = 6'd0;
          mode_nxt = M_FRAC;
        end else if (mode_r == M_RADIX && !e && (is_digit(b) || is_alpha(b))) begin
          adv = 1'b1;
          if (radix_r[63:6] == 58'd0 && d >= radix_r[5:0]) begin
            sl[n] = '{KIND_ERR, 8'd0, T_SYMBOL};
            n = n + 2'd1;
            code = ERR_DIGIT;
            halt_nxt = 1'b1;
          end else begin
            mac_go = 1'b1;
            mac_d = d;
          end
        end else if (mode_r == M_FRAC && !e && is_digit(b)) begin
          adv = 1'b1;
          if (frac_r < FRAC_MAX) begin
            mac_go = 1'b1;
            mac_d = d;
            frac_nxt = frac_r + 6'd1;
          end
        end else begin
          val_out = neg_r ? 64'd0 - accum_r : accum_r;
          frac_out = (mode_r == M_FRAC) ? frac_r : 6'd0;
          sl[n] = '{KIND_DONE, 8'd0, (mode_r == M_FRAC) ? T_FLOAT : T_INT};
          n = n + 2'd1;
          accum_nxt = 64'd0;
          radix_nxt = 64'd10;
          frac_nxt = 6'd0;
          neg_nxt = 1'b0;
          mode_nxt = M_BETWEEN;
          reproc = 1'b1;
        end
      end
      M_STRING: begin
        if (e) begin
          sl[n] = '{KIND_ERR, 8'd0, T_SYMBOL};
          n = n + 2'd1;
          code = ERR_QUOTE;
          halt_nxt = 1'b1;
        end else begin
          adv = 1'b1;
          if (b == "\"") begin
            sl[n] = '{KIND_DONE, 8'd0, T_STRING};
            n = n + 2'd1;
            mode_nxt = M_BETWEEN;
          end else if (b == "\\") begin
            mode_nxt = M_ESC;
          end else begin
            sl[n] = '{KIND_TEXT, b, T_STRING};
            n = n + 2'd1;
          end
        end
      end
      M_ESC: begin
        if (e) begin
          sl[n] = '{KIND_ERR, 8'd0, T_SYMBOL};
          n = n + 2'd1;
          code = ERR_QUOTE;
          halt_nxt = 1'b1;
        end else begin
          adv = 1'b1;
          mode_nxt = M_STRING;
          sl[n] = '{KIND_TEXT, b, T_STRING};
          case (b)
            "a": sl[n].text = 8'd7;
            "b": sl[n].text = 8'd8;
            "e": sl[n].text = ESC_CODE;
            "f": sl[n].text = 8'd12;
            "n": sl[n].text = 8'd10;
            "r": sl[n].text = 8'd13;
            "t": sl[n].text = 8'd9;
            "v": sl[n].text = 8'd11;
            "c": mode_nxt = M_CTRL;
            "x": mode_nxt = M_HEX1;
            default: sl[n].text = b;
          endcase
          if (mode_nxt == M_STRING) n = n + 2'd1;
          else sl[n] = '0;
        end
      end
      M_CTRL: begin
        if (!e) adv = 1'b1;
        if (e || u < CTRL_LO || u > CTRL_HI) begin
          sl[n] = '{KIND_ERR, 8'd0, T_SYMBOL};
          n = n + 2'd1;
          code = ERR_CTRL;
          halt_nxt = 1'b1;
        end else begin
          sl[n] = '{KIND_TEXT, u & CTRL_MASK, T_STRING};
          n = n + 2'd1;
          mode_nxt = M_STRING;
        end
      end
      M_HEX1, M_HEX2: begin
        if (!e) adv = 1'b1;
        if (e || d >= 6'd16) begin
          sl[n] = '{KIND_ERR, 8'd0, T_SYMBOL};
          n = n + 2'd1;
          code = ERR_DIGIT;
          halt_nxt = 1'b1;
        end else if (mode_r == M_HEX1) begin
          esc_nxt = d[3:0];
          mode_nxt = M_HEX2;
        end else begin
          sl[n] = '{KIND_TEXT, {esc_r, d[3:0]}, T_STRING};
          n = n + 2'd1;
          esc_nxt = 4'd0;
          mode_nxt = M_STRING;
        end
      end
      M_COMMENT: begin
        if (e) begin
          sl[n] = '{KIND_DONE, 8'd0, T_END};
          n = n + 2'd1;
          mode_nxt = M_BETWEEN;
        end else begin
          adv = 1'b1;
          if (b == 8'd10) mode_nxt = M_BETWEEN;
        end
      end
      default: begin
        mode_nxt = M_BETWEEN;
        reproc = 1'b1;
      end
    endcase

    if (mode_r == M_BETWEEN || reproc) begin
      if (e) begin
        sl[n] = '{KIND_DONE, 8'd0, T_END};
        n = n + 2'd1;
      end else if (is_space(b)) begin
        adv = 1'b1;
      end else if (b == "(" || b == ")" || b == "'") begin
        adv = 1'b1;
        sl[n] = '{KIND_DONE, 8'd0, (b == "(") ? T_OPEN : (b == ")") ? T_CLOSE : T_QUOTE};
        n = n + 2'd1;
      end else if (b == ";") begin
        adv = 1'b1;
        mode_nxt = M_COMMENT;
      end else if (b == "\"") begin
        adv = 1'b1;
        mode_nxt = M_STRING;
      end else if (is_sign(b)) begin
        adv = 1'b1;
        sign_nxt = b;
        mode_nxt = M_SIGN;
      end else if (is_digit(b)) begin
        adv = 1'b1;
        accum_nxt = 64'(d);
        radix_nxt = 64'd10;
        frac_nxt = 6'd0;
        neg_nxt = 1'b0;
        mode_nxt = M_NUMINT;
      end else if (is_sym_alpha(b)) begin
        adv = 1'b1;
        sl[n] = '{KIND_TEXT, b, T_SYMBOL};
        n = n + 2'd1;
        mode_nxt = M_SYMBOL;
      end else begin
        sl[n] = '{KIND_ERR, 8'd0, T_SYMBOL};
        n = n + 2'd1;
        code = ERR_IDENT;
        halt_nxt = 1'b1;
      end
    end

    line_nxt = line_r;
    col_nxt  = col_r;
    if (adv) begin
      if (b == 8'd10) begin
        if (line_r != 32'hffff_ffff) line_nxt = line_r + 32'd1;
        col_nxt = 16'd0;
      end else if (col_r != 16'hffff) begin
        col_nxt = col_r + 16'd1;
      end
    end
  end

  assign push.valid     = accept && !halt_r && n != 2'd0;
  assign push.data.cnt  = n;
  assign push.data.slot = sl;
  assign push.data.val  = val_out;
  assign push.data.frac = frac_out;
  assign push.data.code = code;
  assign push.data.line = line_nxt;
  assign push.data.col  = col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_BETWEEN;
      accum_r <= 64'd0;
      radix_r <= 64'd10;
      frac_r  <= 6'd0;
      neg_r   <= 1'b0;
      sign_r  <= 8'd0;
      esc_r   <= 4'd0;
      line_r  <= 32'd1;
      col_r   <= 16'd0;
      halt_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else if (busy_r) begin
      accum_r <= pll_r + {mid_r, 32'd0} + 64'(mac_d_r);
      busy_r  <= 1'b0;
    end else if (accept && !halt_r) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      radix_r <= radix_nxt;
      frac_r  <= frac_nxt;
      neg_r   <= neg_nxt;
      sign_r  <= sign_nxt;
      esc_r   <= esc_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      halt_r  <= halt_nxt;
      busy_r  <= mac_go;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mac_go) begin
      pll_r   <= mul_lo;
      mid_r   <= mul_hl + mul_lh;
      mac_d_r <= mac_d;
    end
  end

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r) else $error("multiply-accumulate held more than one cycle");
  a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !halt_r && mac_go) |=> busy_r) else $error("digit did not start accumulate");
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !push.valid) else $error("result pushed after error");

endmodule
`default_nettype wire

>>> src/ltl_fifo.sv
// Queue of per-item result bundles between front and back.
`default_nettype none
module ltl_fifo #(
  parameter int Depth = ltl_pkg::QDEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ltl_pkg::push_t   push,
  output logic                  full,
  output logic                  rd_valid,
  output ltl_pkg::bundle_t      rd_data,
  input  wire logic             rd_ready
);
  import ltl_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  bundle_t        mem [Depth];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;
  logic           do_rd;

  assign full     = cnt_r == CW'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rd_r];
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_r] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) wr_r <= (wr_r == PW'(Depth - 1)) ? '0 : wr_r + PW'(1);
      if (do_rd) rd_r <= (rd_r == PW'(Depth - 1)) ? '0 : rd_r + PW'(1);
      if (push.valid && !do_rd) cnt_r <= cnt_r + CW'(1);
      else if (do_rd && !push.valid) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

>>> src/ltl_back.sv
// Back end: unpacks result bundles into one result item per cycle while the output is ready.
`default_nettype none
module ltl_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire ltl_pkg::bundle_t  q_data,
  output logic                   q_ready,
  ltl_out_if.source              out_chan
);
  import ltl_pkg::*;

  bundle_t    bun_r;
  logic [1:0] idx_r;
  logic       have_r;
  slot_t      cur;
  logic       is_last, fire, is_num;

  assign cur     = bun_r.slot[idx_r];
  assign is_last = idx_r == bun_r.cnt - 2'd1;
  assign fire    = have_r && out_chan.ready;
  assign q_ready = !have_r || (fire && is_last);
  assign is_num  = cur.kind == KIND_DONE && (cur.ttype == T_INT || cur.ttype == T_FLOAT);

  assign out_chan.valid       = have_r;
  assign out_chan.res_kind    = cur.kind;
  assign out_chan.text_byte   = (cur.kind == KIND_TEXT) ? cur.text : 8'd0;
  assign out_chan.tok_class   = cur.ttype;
  assign out_chan.int_value   = is_num ? bun_r.val : 64'd0;
  assign out_chan.frac_digits = (is_num && cur.ttype == T_FLOAT) ? bun_r.frac : 6'd0;
  assign out_chan.error_code  = (cur.kind == KIND_ERR) ? bun_r.code : ERR_DIGIT;
  assign out_chan.err_line    = (cur.kind == KIND_ERR) ? bun_r.line : 32'd0;
  assign out_chan.err_column  = (cur.kind == KIND_ERR) ? bun_r.col : 16'd0;
  assign out_chan.last        = is_last;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) bun_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_valid && q_ready) begin
      have_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (fire) begin
      if (is_last) have_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> src/lisp_token_lexer.sv
// Top level of the Lisp token lexer.
// Takes one source byte (or end-of-input) per item and gives up to three result items
// per input item: text bytes, token-complete records and at most one error, after which
// the block stays silent until reset. An item is taken every cycle while the queue has
// room, except that a digit of a number after its first keeps the front end busy while
// the 64-bit value register is updated through a multiply by the radix that completes in
// the cycle after the digit is taken. Results leave at one per cycle while the output is
// ready; a queue of QueueDepth bundles (two by default) between the lexer and the output
// stage lets either side stall on its own.
`default_nettype none
module lisp_token_lexer #(
  parameter int QueueDepth = ltl_pkg::QDEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ltl_in_if.sink     in_chan,
  ltl_out_if.source  out_chan
);
  import ltl_pkg::*;

  push_t   push;
  logic    q_full, q_valid, q_ready;
  bundle_t q_data;

  ltl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push)
  );

  ltl_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .rd_ready (q_ready)
  );

  ltl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
